[hw/rtl/lmr_pkg.sv]
`timescale 1ns / 1ps

package lmr_pkg;

  // The grid side is a power of two, so a cell index is {row, col}.
  localparam int GRID_MAX = 64;
  localparam int COORD_W  = $clog2(GRID_MAX);
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int CELL_W   = 2 * COORD_W;
  localparam int QCNT_W   = CELL_W + 1;
  localparam int SIZE_W   = 7;
  localparam int LEN_W    = 12;
  localparam int OP_W     = 2;
  localparam int DIR_W    = 2;

  localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ROUTE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Neighbor probe order.
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic load_in;
    logic mark_src;
    logic dst_rd;
    logic dst_wr;
    logic sweep_blk;
    logic sweep_vis;
    logic seed;
    logic pop_rd;
    logic pop_ld;
    logic probe_hit;
    logic next_dir;
    logic trace_init;
    logic trace_rd;
    logic trace_step;
    logic res_ld;
    logic res_routed;
    logic res_use_steps;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ends_in_grid;
    logic            dst_blocked;
    logic            src_eq_dst;
    logic            sweep_last;
    logic            queue_empty;
    logic            nb_off;
    logic            nb_free;
    logic            nb_is_dst;
    logic            dir_last;
    logic            at_src;
  } status_t;

endpackage

[hw/rtl/lmr_ctrl.sv]
`timescale 1ns / 1ps

module lmr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lmr_pkg::status_t  st,
  output lmr_pkg::cmd_t     cmd
);

  typedef enum logic [15:0] {
    S_INIT    = 16'h0001,
    S_IDLE    = 16'h0002,
    S_DEC     = 16'h0004,
    S_DST_RD  = 16'h0008,
    S_DST_CHK = 16'h0010,
    S_VCLR    = 16'h0020,
    S_SEED    = 16'h0040,
    S_POP     = 16'h0080,
    S_POP_W   = 16'h0100,
    S_PROBE   = 16'h0200,
    S_PROBE_W = 16'h0400,
    S_TR_INIT = 16'h0800,
    S_TR_RD   = 16'h1000,
    S_TR_W    = 16'h2000,
    S_CLR     = 16'h4000,
    S_RESP    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_blk = 1'b1;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        priority if (st.op == lmr_pkg::OP_MARK) begin
          cmd.mark_src = 1'b1;
          cmd.res_ld   = 1'b1;
          state_nxt    = S_RESP;
        end else if (st.op == lmr_pkg::OP_CLEAR) begin
          state_nxt = S_CLR;
        end else if (st.op == lmr_pkg::OP_ROUTE && st.ends_in_grid) begin
          state_nxt = S_DST_RD;
        end else begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_DST_RD: begin
        cmd.dst_rd = 1'b1;
        state_nxt  = S_DST_CHK;
      end
      S_DST_CHK: begin
        priority if (st.dst_blocked) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end else if (st.src_eq_dst) begin
          cmd.dst_wr     = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_routed = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_VCLR;
        end
      end
      S_VCLR: begin
        cmd.sweep_vis = 1'b1;
        if (st.sweep_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (st.queue_empty) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_W;
        end
      end
      S_POP_W: begin
        cmd.pop_ld = 1'b1;
        state_nxt  = S_PROBE;
      end
      S_PROBE: begin
        if (st.nb_off) begin
          cmd.next_dir = 1'b1;
          state_nxt    = st.dir_last ? S_POP : S_PROBE;
        end else begin
          state_nxt = S_PROBE_W;
        end
      end
      S_PROBE_W: begin
        if (st.nb_free && st.nb_is_dst) begin
          cmd.probe_hit = 1'b1;
          state_nxt     = S_TR_INIT;
        end else begin
          cmd.probe_hit = st.nb_free;
          cmd.next_dir  = 1'b1;
          state_nxt     = st.dir_last ? S_POP : S_PROBE;
        end
      end
      S_TR_INIT: begin
        cmd.trace_init = 1'b1;
        state_nxt      = S_TR_RD;
      end
      S_TR_RD: begin
        if (st.at_src) begin
          cmd.res_ld        = 1'b1;
          cmd.res_routed    = 1'b1;
          cmd.res_use_steps = 1'b1;
          state_nxt         = S_RESP;
        end else begin
          cmd.trace_rd = 1'b1;
          state_nxt    = S_TR_W;
        end
      end
      S_TR_W: begin
        cmd.trace_step = 1'b1;
        state_nxt      = S_TR_RD;
      end
      S_CLR: begin
        cmd.sweep_blk = 1'b1;
        if (st.sweep_last) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

[hw/rtl/lmr_datapath.sv]
`timescale 1ns / 1ps

module lmr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lmr_pkg::cmd_t                    cmd,
  output lmr_pkg::status_t                 st,
  input  logic                             cfg_we,
  input  logic [lmr_pkg::SIZE_W-1:0]       cfg_grid_size,
  input  logic [lmr_pkg::OP_W-1:0]         in_operation,
  input  logic [lmr_pkg::COORD_W-1:0]      in_src_row,
  input  logic [lmr_pkg::COORD_W-1:0]      in_src_col,
  input  logic [lmr_pkg::COORD_W-1:0]      in_dst_row,
  input  logic [lmr_pkg::COORD_W-1:0]      in_dst_col,
  output logic                             out_routed,
  output logic [lmr_pkg::LEN_W-1:0]        out_path_length
);

  localparam int CW = lmr_pkg::COORD_W;
  localparam int IW = lmr_pkg::CELL_W;
  localparam int DW = lmr_pkg::DIR_W;

  logic                   blk_mem [lmr_pkg::CELLS];
  logic [DW:0]            vis_mem [lmr_pkg::CELLS];
  logic [IW-1:0]          q_mem   [lmr_pkg::CELLS];

  logic [lmr_pkg::SIZE_W-1:0] grid_size_r;
  logic [lmr_pkg::OP_W-1:0]   op_r;
  logic [CW-1:0]              sr_r, sc_r, dr_r, dc_r;
  logic [IW-1:0]              cnt_r, p_r, cell_r;
  logic [lmr_pkg::QCNT_W-1:0] head_r, tail_r;
  logic [DW-1:0]              dir_r;
  logic [lmr_pkg::LEN_W-1:0]  steps_r, len_r;
  logic                       routed_r;
  logic                       blk_q;
  logic [DW:0]                vis_q;
  logic [IW-1:0]              q_q;

  logic [lmr_pkg::SIZE_W-1:0] size;
  logic [IW-1:0]              src_id, dst_id, nb_id, prev_id;
  logic [CW-1:0]              p_row, p_col, nb_row, nb_col, c_row, c_col;
  logic                       src_in, dst_in, nb_off;

  logic                       blk_we, blk_wd;
  logic [IW-1:0]              blk_wa, blk_ra;
  logic                       vis_we;
  logic [DW:0]                vis_wd;
  logic [IW-1:0]              vis_wa, vis_ra;
  logic                       q_we;
  logic [IW-1:0]              q_wa, q_wd;

  always_comb begin
    size = grid_size_r;
    if (grid_size_r < lmr_pkg::SIZE_W'(2)) size = lmr_pkg::SIZE_W'(2);
    if (grid_size_r > lmr_pkg::SIZE_W'(lmr_pkg::GRID_MAX)) begin
      size = lmr_pkg::SIZE_W'(lmr_pkg::GRID_MAX);
    end
  end

  assign src_id = {sr_r, sc_r};
  assign dst_id = {dr_r, dc_r};
  assign src_in = ({1'b0, sr_r} < size) && ({1'b0, sc_r} < size);
  assign dst_in = ({1'b0, dr_r} < size) && ({1'b0, dc_r} < size);

  assign p_row = p_r[IW-1:CW];
  assign p_col = p_r[CW-1:0];

  always_comb begin
    nb_row = p_row;
    nb_col = p_col;
    nb_off = 1'b0;
    unique case (dir_r)
      lmr_pkg::DIR_UP: begin
        nb_row = p_row - CW'(1);
        nb_off = (p_row == '0);
      end
      lmr_pkg::DIR_LEFT: begin
        nb_col = p_col - CW'(1);
        nb_off = (p_col == '0);
      end
      lmr_pkg::DIR_DOWN: begin
        nb_row = p_row + CW'(1);
        nb_off = ({1'b0, p_row} + lmr_pkg::SIZE_W'(1) >= size);
      end
      default: begin
        nb_col = p_col + CW'(1);
        nb_off = ({1'b0, p_col} + lmr_pkg::SIZE_W'(1) >= size);
      end
    endcase
  end
  assign nb_id = {nb_row, nb_col};

  // Step back against the move that reached the current trace cell.
  assign c_row = cell_r[IW-1:CW];
  assign c_col = cell_r[CW-1:0];
  always_comb begin
    prev_id = cell_r;
    unique case (vis_q[DW-1:0])
      lmr_pkg::DIR_UP:   prev_id = {c_row + CW'(1), c_col};
      lmr_pkg::DIR_LEFT: prev_id = {c_row, c_col + CW'(1)};
      lmr_pkg::DIR_DOWN: prev_id = {c_row - CW'(1), c_col};
      default:           prev_id = {c_row, c_col - CW'(1)};
    endcase
  end

  always_comb begin
    blk_we = 1'b1;
    blk_wd = 1'b1;
    blk_wa = cell_r;
    priority if (cmd.sweep_blk) begin
      blk_wa = cnt_r;
      blk_wd = 1'b0;
    end else if (cmd.mark_src) begin
      blk_wa = src_id;
      blk_we = src_in;
    end else if (cmd.dst_wr) begin
      blk_wa = dst_id;
    end else if (cmd.trace_init) begin
      blk_wa = src_id;
    end else if (cmd.trace_step) begin
      blk_wa = cell_r;
    end else begin
      blk_we = 1'b0;
    end
  end
  assign blk_ra = cmd.dst_rd ? dst_id : nb_id;

  always_comb begin
    vis_we = 1'b1;
    vis_wa = nb_id;
    vis_wd = {1'b1, dir_r};
    priority if (cmd.sweep_vis) begin
      vis_wa = cnt_r;
      vis_wd = '0;
    end else if (cmd.seed) begin
      vis_wa = src_id;
      vis_wd = {1'b1, lmr_pkg::DIR_UP};
    end else if (cmd.probe_hit) begin
      vis_wa = nb_id;
    end else begin
      vis_we = 1'b0;
    end
  end
  assign vis_ra = cmd.trace_rd ? cell_r : nb_id;

  always_comb begin
    q_we = 1'b0;
    q_wa = tail_r[IW-1:0];
    q_wd = nb_id;
    if (cmd.seed) begin
      q_we = 1'b1;
      q_wa = '0;
      q_wd = src_id;
    end else if (cmd.probe_hit && (nb_id != dst_id) && !tail_r[IW]) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_q <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_q <= q_mem[head_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= lmr_pkg::SIZE_W'(lmr_pkg::GRID_MAX);
      cnt_r       <= '0;
    end else begin
      if (cfg_we) grid_size_r <= cfg_grid_size;
      if (cmd.sweep_blk || cmd.sweep_vis) cnt_r <= cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_operation;
      sr_r <= in_src_row;
      sc_r <= in_src_col;
      dr_r <= in_dst_row;
      dc_r <= in_dst_col;
    end
    if (cmd.seed) begin
      head_r <= '0;
      tail_r <= lmr_pkg::QCNT_W'(1);
    end else begin
      if (cmd.pop_rd) head_r <= head_r + lmr_pkg::QCNT_W'(1);
      if (q_we) tail_r <= tail_r + lmr_pkg::QCNT_W'(1);
    end
    if (cmd.pop_ld) begin
      p_r   <= q_q;
      dir_r <= lmr_pkg::DIR_UP;
    end else if (cmd.next_dir) begin
      dir_r <= dir_r + DW'(1);
    end
    if (cmd.trace_init) begin
      cell_r  <= dst_id;
      steps_r <= '0;
    end else if (cmd.trace_step) begin
      cell_r <= prev_id;
      if (steps_r != '1) steps_r <= steps_r + lmr_pkg::LEN_W'(1);
    end
    if (cmd.res_ld) begin
      routed_r <= cmd.res_routed;
      len_r    <= cmd.res_use_steps ? steps_r : '0;
    end
  end

  assign out_routed      = routed_r;
  assign out_path_length = len_r;

  assign st.op           = op_r;
  assign st.ends_in_grid = src_in && dst_in;
  assign st.dst_blocked  = blk_q;
  assign st.src_eq_dst   = (src_id == dst_id);
  assign st.sweep_last   = (cnt_r == '1);
  assign st.queue_empty  = (head_r == tail_r);
  assign st.nb_off       = nb_off;
  assign st.nb_free      = !blk_q && !vis_q[DW];
  assign st.nb_is_dst    = (nb_id == dst_id);
  assign st.dir_last     = (dir_r == lmr_pkg::DIR_RIGHT);
  assign st.at_src       = (cell_r == src_id);

endmodule

[hw/rtl/lee_maze_grid_router.sv]
`timescale 1ns / 1ps

// Lee maze router over a square grid of up to 64 by 64 cells with a
// one-bit obstacle map. Each request marks one in-grid cell blocked,
// clears every obstacle, or routes one net by a breadth-first wave (probe
// order up, left, down, right) and, if a path is found, blocks the
// source, target and every path cell; exactly one result (routed,
// path_length) comes back per request. The block works on one request
// at a time and drives in_stall high from acceptance until its result
// has been taken. All grid state lives in memories with one write and
// one registered read port, so each step of the sequencer costs one
// memory access: a mark writes one cell, a clear sweeps every cell, a
// route sweeps the visited map, reads each dequeued cell, probes each
// in-grid neighbor and steps back cell by cell on trace-back. After
// reset the obstacle map is cleared in one pass over all 4096 cells
// before the first request is taken; configuration writes are accepted
// at any time and must only be issued while the block is idle.
module lee_maze_grid_router (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lmr_pkg::OP_W-1:0]         in_operation,
  input  logic [lmr_pkg::COORD_W-1:0]      in_src_row,
  input  logic [lmr_pkg::COORD_W-1:0]      in_src_col,
  input  logic [lmr_pkg::COORD_W-1:0]      in_dst_row,
  input  logic [lmr_pkg::COORD_W-1:0]      in_dst_col,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_routed,
  output logic [lmr_pkg::LEN_W-1:0]        out_path_length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lmr_pkg::SIZE_W-1:0]       cfg_grid_size
);

  lmr_pkg::cmd_t    cmd;
  lmr_pkg::status_t st;

  // The grid size register can always take a write.
  assign cfg_ready = 1'b1;

  lmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lmr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_grid_size   (cfg_grid_size),
    .in_operation    (in_operation),
    .in_src_row      (in_src_row),
    .in_src_col      (in_src_col),
    .in_dst_row      (in_dst_row),
    .in_dst_col      (in_dst_col),
    .out_routed      (out_routed),
    .out_path_length (out_path_length)
  );

endmodule
